[rtl/mlc_pkg.sv]
package mlc_pkg;

  localparam int PREFIX_LEN       = 7;
  localparam int LEN_BITS         = 3;
  localparam int OFFSET_BITS_DEF  = 32;
  localparam int MAX_HEADING_DEF  = 6;
  localparam int OUT_OFFSET_BITS  = 32;

  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_NL     = 8'h0a;

  typedef enum logic [3:0] {
    K_PARA    = 4'd0,
    K_BLANK   = 4'd1,
    K_HEADING = 4'd2,
    K_QUOTE   = 4'd3,
    K_TASK    = 4'd4,
    K_LIST    = 4'd5,
    K_TABLE   = 4'd6,
    K_CODE    = 4'd7,
    K_MATH    = 4'd8
  } kind_t;

  typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] level;
    logic       checked;
    logic       flip_code;
    logic       flip_math;
  } class_t;

endpackage

[rtl/markdown_line_classifier.sv]
// Channel  Direction  Payload
// s_axis   in         tdata = char_in, tlast = end_mark
// m_axis   out        tdata = line_start, line_stop, heading_level, checked;
//                     tuser = kind, tlast = last_block
//
// One item per cycle; an item is registered, then classified and its line
// record registered. Synchronous reset clears the offsets, line prefix and
// fence flags. A stalled result holds the record; the input register still
// takes one item and then s_tready drops until m_tready frees the result
// register.
module markdown_line_classifier #(
  parameter int OFFSET_BITS = mlc_pkg::OFFSET_BITS_DEF,
  parameter int MAX_HEADING = mlc_pkg::MAX_HEADING_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] line_start, [63:32] line_stop,
                                 // [66:64] heading_level, [67] checked, [71:68] zero
  output logic [3:0]  m_tuser,   // [3:0] kind
  output logic        m_tlast
);
  import mlc_pkg::*;

  logic                   in_vld;
  logic [7:0]             in_char;
  logic                   in_end;
  logic                   advance;
  logic                   emit;
  logic [OFFSET_BITS-1:0] rec_start;
  logic [OFFSET_BITS-1:0] rec_stop;
  class_t                 cls;
  logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] start_wide;
  logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] stop_wide;

  logic [OUT_OFFSET_BITS-1:0] out_start;
  logic [OUT_OFFSET_BITS-1:0] out_stop;
  kind_t                      out_kind;
  logic [2:0]                 out_level;
  logic                       out_checked;
  logic                       out_last;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  mlc_tracker #(.OFFSET_BITS(OFFSET_BITS), .MAX_HEADING(MAX_HEADING)) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_in   (in_char),
    .end_mark  (in_end),
    .emit      (emit),
    .rec_start (rec_start),
    .rec_stop  (rec_stop),
    .cls       (cls)
  );

  assign start_wide = {{OUT_OFFSET_BITS{1'b0}}, rec_start};
  assign stop_wide  = {{OUT_OFFSET_BITS{1'b0}}, rec_stop};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_start   <= start_wide[OUT_OFFSET_BITS-1:0];
      out_stop    <= stop_wide[OUT_OFFSET_BITS-1:0];
      out_kind    <= cls.kind;
      out_level   <= cls.level;
      out_checked <= cls.checked;
      out_last    <= in_end;
    end
  end

  assign m_tdata = {4'b0, out_checked, out_level, out_stop, out_start};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  a_level_only_heading: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_kind != K_HEADING)) |-> (out_level == 3'd0))
    else $error("heading level set on a non-heading line");

  a_checked_only_task: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_checked) |-> (out_kind == K_TASK))
    else $error("checked mark on a non-task line");

  a_heading_level_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_kind == K_HEADING)) |->
      ((out_level != 3'd0) && (out_level <= 3'(MAX_HEADING))))
    else $error("heading level out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");

endmodule

[rtl/mlc_classify.sv]
module mlc_classify #(
  parameter int MAX_HEADING = mlc_pkg::MAX_HEADING_DEF
) (
  input  mlc_pkg::prefix_t              prefix,
  input  logic [mlc_pkg::LEN_BITS-1:0]  len,
  input  logic                          inside_code,
  input  logic                          inside_math,
  output mlc_pkg::class_t               cls
);
  import mlc_pkg::*;

  logic [2:0] hashes;
  logic       run;
  logic       space_after;
  logic       is_code;
  logic       is_math;
  logic       task_frame;
  logic       is_heading;
  logic       is_list;

  always_comb begin
    hashes = 3'd0;
    run    = 1'b1;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (run && (3'(i) < len) && (prefix[i] == CH_HASH)) begin
        hashes = hashes + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    space_after = 1'b0;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (hashes == 3'(i)) begin
        space_after = (prefix[i] == CH_SPACE);
      end
    end
  end

  assign is_code = (len >= 3'd3) && (prefix[0] == CH_TICK) && (prefix[1] == CH_TICK) &&
                   (prefix[2] == CH_TICK);
  assign is_math = (len >= 3'd2) && (prefix[0] == CH_DOLLAR) && (prefix[1] == CH_DOLLAR);
  assign task_frame = (len >= 3'd6) && (prefix[0] == CH_DASH) && (prefix[1] == CH_SPACE) &&
                      (prefix[2] == CH_LBRACK) && (prefix[4] == CH_RBRACK) &&
                      (prefix[5] == CH_SPACE);
  assign is_heading = (hashes != 3'd0) && (hashes <= 3'(MAX_HEADING)) && (hashes < len) &&
                      (hashes != 3'd7) && space_after;
  assign is_list = (len >= 3'd2) && (prefix[1] == CH_SPACE) &&
                   ((prefix[0] == CH_DASH) || (prefix[0] == CH_STAR));

  always_comb begin
    cls = '{kind: K_PARA, level: 3'd0, checked: 1'b0, flip_code: 1'b0, flip_math: 1'b0};
    if (is_code) begin
      cls.kind      = K_CODE;
      cls.flip_code = 1'b1;
    end else if (is_math) begin
      cls.kind      = K_MATH;
      cls.flip_math = 1'b1;
    end else if (inside_code) begin
      cls.kind = K_CODE;
    end else if (inside_math) begin
      cls.kind = K_MATH;
    end else if (len == 3'd0) begin
      cls.kind = K_BLANK;
    end else if (prefix[0] == CH_HASH) begin
      if (is_heading) begin
        cls.kind  = K_HEADING;
        cls.level = hashes;
      end
    end else if (prefix[0] == CH_GT) begin
      cls.kind = K_QUOTE;
    end else if (task_frame && ((prefix[3] == CH_LOW_X) || (prefix[3] == CH_UP_X))) begin
      cls.kind    = K_TASK;
      cls.checked = 1'b1;
    end else if (task_frame && (prefix[3] == CH_SPACE)) begin
      cls.kind = K_TASK;
    end else if (is_list) begin
      cls.kind = K_LIST;
    end else if (prefix[0] == CH_PIPE) begin
      cls.kind = K_TABLE;
    end
  end

endmodule

[rtl/mlc_tracker.sv]
module mlc_tracker #(
  parameter int OFFSET_BITS = mlc_pkg::OFFSET_BITS_DEF,
  parameter int MAX_HEADING = mlc_pkg::MAX_HEADING_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             char_in,
  input  logic                   end_mark,
  output logic                   emit,
  output logic [OFFSET_BITS-1:0] rec_start,
  output logic [OFFSET_BITS-1:0] rec_stop,
  output mlc_pkg::class_t        cls
);
  import mlc_pkg::*;

  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] line_origin, line_origin_next;
  prefix_t                prefix_chars, prefix_chars_next;
  logic [LEN_BITS-1:0]    line_length, line_length_next;
  logic                   inside_code, inside_code_next;
  logic                   inside_math, inside_math_next;
  logic [OFFSET_BITS-1:0] position_inc;
  logic                   is_nl;

  mlc_classify #(.MAX_HEADING(MAX_HEADING)) u_classify (
    .prefix      (prefix_chars),
    .len         (line_length),
    .inside_code (inside_code),
    .inside_math (inside_math),
    .cls         (cls)
  );

  assign position_inc = (&position) ? position : position + 1'b1;
  assign is_nl        = (char_in == CH_NL);
  assign emit         = end_mark || is_nl;
  assign rec_start    = line_origin;
  assign rec_stop     = position;

  always_comb begin
    position_next     = position;
    line_origin_next  = line_origin;
    prefix_chars_next = prefix_chars;
    line_length_next  = line_length;
    inside_code_next  = inside_code;
    inside_math_next  = inside_math;
    if (step) begin
      if (end_mark) begin
        position_next     = '0;
        line_origin_next  = '0;
        prefix_chars_next = '0;
        line_length_next  = '0;
        inside_code_next  = 1'b0;
        inside_math_next  = 1'b0;
      end else if (is_nl) begin
        inside_code_next  = inside_code ^ cls.flip_code;
        inside_math_next  = inside_math ^ cls.flip_math;
        position_next     = position_inc;
        line_origin_next  = position_inc;
        prefix_chars_next = '0;
        line_length_next  = '0;
      end else begin
        position_next = position_inc;
        if (line_length != LEN_BITS'(PREFIX_LEN)) begin
          for (int i = 0; i < PREFIX_LEN; i++) begin
            if (line_length == LEN_BITS'(i)) begin
              prefix_chars_next[i] = char_in;
            end
          end
          line_length_next = line_length + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      line_origin  <= '0;
      prefix_chars <= '0;
      line_length  <= '0;
      inside_code  <= 1'b0;
      inside_math  <= 1'b0;
    end else begin
      position     <= position_next;
      line_origin  <= line_origin_next;
      prefix_chars <= prefix_chars_next;
      line_length  <= line_length_next;
      inside_code  <= inside_code_next;
      inside_math  <= inside_math_next;
    end
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  import mlc_pkg::*;

  localparam int IDLE_PCT       = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 750;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    kind_t       kind;
    logic [2:0]  level;
    logic        checked;
    logic        last;
  } line_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  markdown_line_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // line classifier model state
  logic [31:0] pred_pos;
  logic [31:0] pred_origin;
  logic [7:0]  pred_prefix [PREFIX_LEN];
  logic [2:0]  pred_len;
  logic        pred_code;
  logic        pred_math;

  line_rec_t line_records_due [$];
  line_rec_t got_rec;

  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  int items_sent = 0;
  int texts_sent = 0;
  int records_checked = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int kind_seen [9];

  function automatic logic [31:0] sat_next(input logic [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 32'd1;
  endfunction

  // pat holds the leading bytes, first byte in the lowest bits
  function automatic bit lead_is(input logic [47:0] pat, input int n);
    int i;
    if (pred_len < n) return 1'b0;
    for (i = 0; i < n; i++)
      if (pred_prefix[i] != pat[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_line;
    int i;
    for (i = 0; i < PREFIX_LEN; i++) pred_prefix[i] = 8'h00;
    pred_len = 3'd0;
  endtask

  task automatic clear_text;
    pred_pos = 32'd0;
    pred_origin = 32'd0;
    pred_code = 1'b0;
    pred_math = 1'b0;
    clear_line();
  endtask

  task automatic close_line(input logic last);
    line_rec_t rec;
    int n;
    rec.start = pred_origin;
    rec.stop = pred_pos;
    rec.kind = K_PARA;
    rec.level = 3'd0;
    rec.checked = 1'b0;
    rec.last = last;
    if (lead_is({24'h0, CH_TICK, CH_TICK, CH_TICK}, 3)) begin
      rec.kind = K_CODE;
      pred_code = ~pred_code;
    end else if (lead_is({32'h0, CH_DOLLAR, CH_DOLLAR}, 2)) begin
      rec.kind = K_MATH;
      pred_math = ~pred_math;
    end else if (pred_code) begin
      rec.kind = K_CODE;
    end else if (pred_math) begin
      rec.kind = K_MATH;
    end else if (pred_len == 0) begin
      rec.kind = K_BLANK;
    end else if (pred_prefix[0] == CH_HASH) begin
      n = 0;
      while (n < pred_len && pred_prefix[n] == CH_HASH) n++;
      if (n >= 1 && n <= MAX_HEADING_DEF && n < pred_len && n < PREFIX_LEN &&
          pred_prefix[n] == CH_SPACE) begin
        rec.kind = K_HEADING;
        rec.level = n[2:0];
      end
    end else if (pred_prefix[0] == CH_GT) begin
      rec.kind = K_QUOTE;
    end else if (lead_is({CH_SPACE, CH_RBRACK, CH_LOW_X, CH_LBRACK, CH_SPACE, CH_DASH}, 6) ||
                 lead_is({CH_SPACE, CH_RBRACK, CH_UP_X, CH_LBRACK, CH_SPACE, CH_DASH}, 6)) begin
      rec.kind = K_TASK;
      rec.checked = 1'b1;
    end else if (lead_is({CH_SPACE, CH_RBRACK, CH_SPACE, CH_LBRACK, CH_SPACE, CH_DASH}, 6)) begin
      rec.kind = K_TASK;
    end else if (lead_is({32'h0, CH_SPACE, CH_DASH}, 2) ||
                 lead_is({32'h0, CH_SPACE, CH_STAR}, 2)) begin
      rec.kind = K_LIST;
    end else if (pred_prefix[0] == CH_PIPE) begin
      rec.kind = K_TABLE;
    end
    line_records_due.insert(line_records_due.size(), rec);
  endtask

  task automatic classify_item(input logic [7:0] ch, input logic mark);
    if (mark) begin
      close_line(1'b1);
      clear_text();
    end else if (ch == CH_NL) begin
      close_line(1'b0);
      pred_pos = sat_next(pred_pos);
      pred_origin = pred_pos;
      clear_line();
    end else begin
      if (pred_len < PREFIX_LEN) begin
        pred_prefix[pred_len] = ch;
        pred_len = pred_len + 3'd1;
      end
      pred_pos = sat_next(pred_pos);
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic mark);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= mark;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_item(ch, mark);
    items_sent++;
    if (mark) texts_sent++;
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_line(input string s);
    send_str(s);
    send_char(CH_NL, 1'b0);
  endtask

  task automatic end_text;
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic code_fence_line;
    repeat (3) send_char(CH_TICK, 1'b0);
    send_char(CH_NL, 1'b0);
  endtask

  task automatic wait_for_records;
    s_tvalid <= 1'b0;
    while (line_records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_line_kinds;
    send_line("plain");
    send_line("");
    send_line("> q");
    send_line("|a|");
    send_line("- li");
    send_line("* st");
    send_line("- [x] t");
    send_line("- [X] t");
    send_line("- [ ] t");
    send_line("- [y] t");
    send_line("- [x]");
    send_line("-x");
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_NL, 1'b0);
    end_text();
    wait_for_records();
  endtask

  task automatic test_headings;
    send_line("# a");
    send_line("###### a");
    send_line("####### a");
    send_line("#a");
    send_line("#");
    send_line("#######");
    send_line("##  x");
    end_text();
    wait_for_records();
  endtask

  task automatic test_fences;
    code_fence_line();
    send_line("# not");
    send_line("$$");
    send_line("in");
    code_fence_line();
    send_line("x");
    send_line("$$");
    repeat (2) send_char(CH_TICK, 1'b0);
    send_char(CH_NL, 1'b0);
    send_line("$");
    send_line("$$");
    send_str("open");
    end_text();
    // flags must be closed in the next text
    code_fence_line();
    end_text();
    send_str("a");
    end_text();
    wait_for_records();
  endtask

  task automatic test_text_boundaries;
    end_text();
    send_str("abc");
    end_text();
    send_line("abc");
    end_text();
    send_line("abcdefg####### and a line well past the stored prefix");
    send_line("");
    send_line("");
    end_text();
    wait_for_records();
  endtask

  task automatic test_output_stall;
    tx_idle_pct = 0;
    hold_start <= 1'b1;
    repeat (30) send_line("- a");
    end_text();
    wait_for_records();
    tx_idle_pct = IDLE_PCT;
  endtask

  task automatic send_random_line(input bit with_nl);
    int tmpl;
    int tail;
    int i;
    logic [7:0] b;
    tmpl = $urandom_range(0, 19);
    case (tmpl)
      0: repeat (3) send_char(CH_TICK, 1'b0);
      1: send_str("$$");
      3: send_str("# ");
      4: send_str("### ");
      5: send_str("###### ");
      6: send_str("####### ");
      7: send_str("#");
      8: send_str(">");
      9: send_str("- [x] ");
      10: send_str("- [X] ");
      11: send_str("- [ ] ");
      12: send_str("- [");
      13: send_str("- ");
      14: send_str("* ");
      15: send_str("|");
      16: repeat (2) send_char(CH_TICK, 1'b0);
      17: send_str("$");
      default: ;
    endcase
    if (tmpl == 2) tail = 0;
    else if ($urandom_range(0, 19) == 0) tail = $urandom_range(8, 48);
    else tail = $urandom_range(0, 8);
    for (i = 0; i < tail; i++) begin
      if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
      send_char(b, 1'b0);
    end
    if (with_nl) send_char(CH_NL, 1'b0);
  endtask

  task automatic test_random_texts;
    int first;
    int lines;
    int k;
    bit trailing_nl;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first >= 300 && items_sent - first < 600) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      lines = $urandom_range(1, 8);
      trailing_nl = $urandom_range(0, 1);
      for (k = 0; k < lines; k++) send_random_line(k < lines - 1 || trailing_nl);
      end_text();
    end
    wait_for_records();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (line_records_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: line record with none expected: tdata %h tuser %h tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        got_rec = line_records_due.pop_front();
        check_field("line_start", got_rec.start, m_tdata[31:0]);
        check_field("line_stop", got_rec.stop, m_tdata[63:32]);
        check_field("heading_level", {29'h0, got_rec.level}, {29'h0, m_tdata[66:64]});
        check_field("checked", {31'h0, got_rec.checked}, {31'h0, m_tdata[67]});
        check_field("kind", {28'h0, got_rec.kind}, {28'h0, m_tuser});
        check_field("last_block", {31'h0, got_rec.last}, {31'h0, m_tlast});
        records_checked++;
        kind_seen[got_rec.kind]++;
      end
    end
  end

  // hold off for a long stretch on request, else random ready
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start <= 1'b0;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clear_text();
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_line_kinds();
    test_headings();
    test_fences();
    test_text_boundaries();
    test_output_stall();
    test_random_texts();
    $display("covered %0d items in %0d texts, %0d line records checked",
             items_sent, texts_sent, records_checked);
    $display("by kind: para %0d blank %0d heading %0d quote %0d task %0d list %0d %s %0d %0d %0d",
             kind_seen[K_PARA], kind_seen[K_BLANK], kind_seen[K_HEADING],
             kind_seen[K_QUOTE], kind_seen[K_TASK], kind_seen[K_LIST],
             "table/code/math", kind_seen[K_TABLE], kind_seen[K_CODE], kind_seen[K_MATH]);
    if (mismatch_count == 0 && line_records_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
